@@ hw/rtl/rlbs_pkg.sv @@
// Shared types and constants for the RGB LED chain bit serializer.
// No dependencies; every other file in hw/rtl refers to it by scoped names.
package rlbs_pkg;

  // Chain length and derived widths
  localparam int NUM_LEDS         = 64;
  localparam int LED_AW           = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
  localparam int SLOTS_PER_PERIOD = 24;
  localparam int EXTRA_POST       = 20;

  localparam int PC_W       = 12;
  localparam int BP_W       = 5;
  localparam int DUTY_W     = 16;
  localparam int PERIOD_W   = 10;
  localparam int LED_NUM_W  = 10;
  localparam int COLOR_W    = 24;
  localparam int CFG_IDX_W  = 2;

  // Color write index limit, one bit wider than led_number
  localparam logic [LED_NUM_W:0] LED_LIMIT = (LED_NUM_W + 1)'(NUM_LEDS);

  typedef enum logic [1:0] {
    FN_WRITE = 2'd0,
    FN_START = 2'd1,
    FN_SLOT  = 2'd2,
    FN_NONE  = 2'd3
  } func_e_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_BUSY  = 2'd1,
    ST_RANGE = 2'd2,
    ST_IDLE  = 2'd3
  } status_e_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PRE  = 2'd0,
    CFG_POST = 2'd1,
    CFG_ONE  = 2'd2,
    CFG_ZERO = 2'd3
  } cfg_reg_e_t;

  typedef struct packed {
    logic [1:0]           func;
    logic [LED_NUM_W-1:0] led_number;
    logic [7:0]           green;
    logic [7:0]           red;
    logic [7:0]           blue;
  } in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [DUTY_W-1:0] duty;
    logic              last;
    logic              busy_res;
  } out_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] reset_pre_periods;
    logic [PERIOD_W-1:0] reset_post_periods;
    logic [DUTY_W-1:0]   duty_one;
    logic [DUTY_W-1:0]   duty_zero;
  } cfg_t;

  // Color store access, issued when an item leaves the input register
  typedef struct packed {
    logic               wr_en;
    logic [LED_AW-1:0]  wr_addr;
    logic [COLOR_W-1:0] wr_data;
    logic               rd_en;
    logic [LED_AW-1:0]  rd_addr;
  } mem_req_t;

  // Per-item outcome carried from the sequencer to the output stage
  typedef struct packed {
    logic [1:0]      status;
    logic            last;
    logic            busy;
    logic            is_data;
    logic [BP_W-1:0] bit_idx;
  } slot_res_t;

endpackage

@@ hw/rtl/rlbs_cfg_regs.sv @@
// Configuration register file for the serializer (frame timing and duty codes).
// Depends on rlbs_pkg.
module rlbs_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [rlbs_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [rlbs_pkg::DUTY_W-1:0]    wr_data,
  output rlbs_pkg::cfg_t                 cfg
);

  rlbs_pkg::cfg_t cfg_r;
  rlbs_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (rlbs_pkg::cfg_reg_e_t'(wr_index))
        rlbs_pkg::CFG_PRE:  cfg_nxt.reset_pre_periods  = wr_data[rlbs_pkg::PERIOD_W-1:0];
        rlbs_pkg::CFG_POST: cfg_nxt.reset_post_periods = wr_data[rlbs_pkg::PERIOD_W-1:0];
        rlbs_pkg::CFG_ONE:  cfg_nxt.duty_one           = wr_data;
        rlbs_pkg::CFG_ZERO: cfg_nxt.duty_zero          = wr_data;
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reset_pre_periods  <= rlbs_pkg::PERIOD_W'(50);
      cfg_r.reset_post_periods <= rlbs_pkg::PERIOD_W'(50);
      cfg_r.duty_one           <= rlbs_pkg::DUTY_W'(60);
      cfg_r.duty_zero          <= rlbs_pkg::DUTY_W'(30);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ hw/rtl/rlbs_color_mem.sv @@
// Color store: one GRB entry per LED, registered read, per-entry valid bits.
// Depends on rlbs_pkg. An entry never written reads with rd_hit low.
module rlbs_color_mem (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rlbs_pkg::mem_req_t           req,
  output logic [rlbs_pkg::COLOR_W-1:0] rd_data,
  output logic                         rd_hit
);

  logic [rlbs_pkg::COLOR_W-1:0]  mem_r [rlbs_pkg::NUM_LEDS];
  logic [rlbs_pkg::NUM_LEDS-1:0] valid_r;
  logic [rlbs_pkg::COLOR_W-1:0]  rd_data_r;
  logic                          rd_hit_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem_r[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem_r[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_hit_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        valid_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_hit_r <= valid_r[req.rd_addr];
      end
    end
  end

  assign rd_data = rd_data_r;
  assign rd_hit  = rd_hit_r;

endmodule

@@ hw/rtl/rlbs_slot_seq.sv @@
// Command decoder and frame sequencer: frame state, period and bit counters.
// Depends on rlbs_pkg; issues color store requests consumed by rlbs_color_mem.
module rlbs_slot_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  rlbs_pkg::in_t       item,
  input  rlbs_pkg::cfg_t      cfg,
  output rlbs_pkg::mem_req_t  mem_req,
  output rlbs_pkg::slot_res_t res
);

  logic                      active_r, active_nxt;
  logic [rlbs_pkg::PC_W-1:0] pc_r, pc_nxt;
  logic [rlbs_pkg::BP_W-1:0] bp_r, bp_nxt;

  logic [rlbs_pkg::PC_W-1:0] pre_ext;
  logic [rlbs_pkg::PC_W-1:0] total;
  logic [rlbs_pkg::PC_W-1:0] led_off;
  logic [rlbs_pkg::PC_W-1:0] pc_inc;
  logic [rlbs_pkg::BP_W-1:0] bp_inc;
  logic                      in_data;
  logic                      led_ok;

  assign pre_ext = rlbs_pkg::PC_W'(cfg.reset_pre_periods);
  assign total   = pre_ext + rlbs_pkg::PC_W'(rlbs_pkg::NUM_LEDS)
                 + rlbs_pkg::PC_W'(cfg.reset_post_periods)
                 + rlbs_pkg::PC_W'(rlbs_pkg::EXTRA_POST);
  assign led_off = pc_r - pre_ext;
  assign in_data = (pc_r >= pre_ext) &&
                   (pc_r < pre_ext + rlbs_pkg::PC_W'(rlbs_pkg::NUM_LEDS));
  assign pc_inc  = pc_r + rlbs_pkg::PC_W'(1);
  assign bp_inc  = bp_r + rlbs_pkg::BP_W'(1);
  assign led_ok  = {1'b0, item.led_number} < rlbs_pkg::LED_LIMIT;

  always_comb begin
    active_nxt      = active_r;
    pc_nxt          = pc_r;
    bp_nxt          = bp_r;
    res             = '0;
    res.status      = rlbs_pkg::ST_OK;
    mem_req         = '0;
    mem_req.wr_addr = item.led_number[rlbs_pkg::LED_AW-1:0];
    mem_req.wr_data = {item.green, item.red, item.blue};
    mem_req.rd_addr = led_off[rlbs_pkg::LED_AW-1:0];
    res.bit_idx     = rlbs_pkg::BP_W'(rlbs_pkg::SLOTS_PER_PERIOD - 1) - bp_r;

    unique case (rlbs_pkg::func_e_t'(item.func))
      rlbs_pkg::FN_WRITE: begin
        if (led_ok) begin
          mem_req.wr_en = fire;
        end else begin
          res.status = rlbs_pkg::ST_RANGE;
        end
      end
      rlbs_pkg::FN_START: begin
        if (active_r) begin
          res.status = rlbs_pkg::ST_BUSY;
        end else begin
          active_nxt = 1'b1;
          pc_nxt     = '0;
          bp_nxt     = '0;
        end
      end
      rlbs_pkg::FN_SLOT: begin
        if (!active_r) begin
          res.status = rlbs_pkg::ST_IDLE;
        end else begin
          res.is_data   = in_data;
          mem_req.rd_en = fire && in_data;
          bp_nxt        = bp_inc;
          // close the LED period; the frame ends once the period total is reached
          if (bp_inc >= rlbs_pkg::BP_W'(rlbs_pkg::SLOTS_PER_PERIOD)) begin
            bp_nxt = '0;
            pc_nxt = pc_inc;
            if (pc_inc >= total) begin
              active_nxt = 1'b0;
              pc_nxt     = '0;
              res.last   = 1'b1;
            end
          end
        end
      end
      rlbs_pkg::FN_NONE: begin
        res.status = rlbs_pkg::ST_OK;
      end
      default: begin
        res.status = rlbs_pkg::ST_OK;
      end
    endcase
    res.busy = active_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      pc_r     <= '0;
      bp_r     <= '0;
    end else if (fire) begin
      active_r <= active_nxt;
      pc_r     <= pc_nxt;
      bp_r     <= bp_nxt;
    end
  end

  a_bp_range: assert property (@(posedge clk) disable iff (!rst_n)
    bp_r < rlbs_pkg::BP_W'(rlbs_pkg::SLOTS_PER_PERIOD))
    else $error("bit position left its LED period");

  a_idle_counters: assert property (@(posedge clk) disable iff (!rst_n)
    !active_r |-> (pc_r == '0 && bp_r == '0))
    else $error("counters not parked while no frame runs");

endmodule

@@ hw/rtl/rgb_led_chain_bit_serializer_core.sv @@
// Top level of the RGB LED chain bit serializer: three-stage item pipeline.
// Depends on rlbs_pkg, rlbs_cfg_regs, rlbs_color_mem and rlbs_slot_seq.
//
// The core takes one command item per clock cycle while in_stall is low and
// returns exactly one result item for each: color writes into a 64-entry GRB
// store, frame starts, and bit-slot requests that return the PWM compare value
// for the next slot of the frame (zero-duty reset periods, each LED's 24 bits
// MSB first, then trailing reset periods plus 20). Throughput is one item per
// cycle while the output is not stalled; each item passes through the input
// register, the sequencer with the color store read, and the output register,
// where the store's registered read port sits in the middle stage. Each
// stage holds its item while the one after it is full and stalled, so empty
// stages keep absorbing input while a result waits at the output. The color
// store reads as zero after reset through per-entry valid bits, so no clearing
// pass is needed. Configuration writes are taken at any time (cfg_ready is
// always high) and are meant to land while the core is idle.
module rgb_led_chain_bit_serializer_core (
  input  logic                           clk,
  input  logic                           rst_n,
  // command items
  input  logic                           in_valid,
  output logic                           in_stall,
  input  rlbs_pkg::in_t                  in_item,
  // result items
  output logic                           out_valid,
  input  logic                           out_stall,
  output rlbs_pkg::out_t                 out_item,
  // register writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rlbs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rlbs_pkg::DUTY_W-1:0]    cfg_data
);

  rlbs_pkg::cfg_t               cfg;
  rlbs_pkg::mem_req_t           mem_req;
  rlbs_pkg::slot_res_t          seq_res;
  logic [rlbs_pkg::COLOR_W-1:0] rd_data;
  logic                         rd_hit;

  // stage 1: input register
  logic          v1_r;
  rlbs_pkg::in_t in_r;
  // stage 2: decoded outcome, color word arrives from the store register
  logic                v2_r;
  rlbs_pkg::slot_res_t s2_r;
  // stage 3: result register
  logic           out_valid_r;
  rlbs_pkg::out_t out_r;
  rlbs_pkg::out_t out_nxt;

  logic en_o, en2, en1, fire;
  logic slot_bit;

  // advance a stage when the next one is empty or moving
  assign en_o = !out_valid_r || !out_stall;
  assign en2  = !v2_r || en_o;
  assign en1  = !v1_r || en2;
  assign fire = v1_r && en2;

  assign in_stall  = !en1;
  assign cfg_ready = 1'b1;

  rlbs_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // frame state advances when an item leaves the input register
  rlbs_slot_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .item    (in_r),
    .cfg     (cfg),
    .mem_req (mem_req),
    .res     (seq_res)
  );

  // read data is loaded only together with stage 2, so it holds while stalled
  rlbs_color_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mem_req),
    .rd_data (rd_data),
    .rd_hit  (rd_hit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= in_valid;
    end
    if (en1 && in_valid) begin
      in_r <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= v1_r;
    end
    if (fire) begin
      s2_r <= seq_res;
    end
  end

  // pick the slot's bit and map it to a compare value
  assign slot_bit = rd_hit && rd_data[s2_r.bit_idx];

  always_comb begin
    out_nxt.status   = s2_r.status;
    out_nxt.last     = s2_r.last;
    out_nxt.busy_res = s2_r.busy;
    if (s2_r.is_data) begin
      out_nxt.duty = slot_bit ? cfg.duty_one : cfg.duty_zero;
    end else begin
      out_nxt.duty = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en_o) begin
      out_valid_r <= v2_r;
    end
    if (en_o && v2_r) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.last) |-> !out_item.busy_res)
    else $error("final slot reported with frame still running");

  a_duty_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.duty != '0) |-> (out_item.status == rlbs_pkg::ST_OK))
    else $error("nonzero duty on a refused or idle item");

  a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v1_r && v2_r && out_valid_r))
    else $error("input stalled while a pipeline stage was empty");

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for rgb_led_chain_bit_serializer_core.
// Needs only rlbs_pkg and the core RTL. It predicts every reply from its own model of the
// color store and the frame sequencer, inserts random input gaps and stalls the output at random.
module tb_top;

  // A correct run ends long before this limit; it only catches a hang
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_CYCLES = 150;

  // DUT connections; the driven ones are known from time zero
  logic                           clk       = 1'b0;
  logic                           rst_n     = 1'b0;
  logic                           in_valid  = 1'b0;
  logic                           in_stall;
  rlbs_pkg::in_t                  in_item   = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  rlbs_pkg::out_t                 out_item;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [rlbs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [rlbs_pkg::DUTY_W-1:0]    cfg_data  = '0;

  // Shadow of the block's state: color store, frame position and registers
  logic [rlbs_pkg::COLOR_W-1:0] grb_store [rlbs_pkg::NUM_LEDS];
  logic                         frame_on;
  logic [rlbs_pkg::PC_W-1:0]    period_cnt;
  logic [rlbs_pkg::BP_W-1:0]    slot_bit;
  rlbs_pkg::cfg_t               regs_shadow;

  // Items waiting to be driven and replies waiting to be seen
  rlbs_pkg::in_t  pending_cmds [$];
  rlbs_pkg::out_t expected_replies [$];

  int items_queued   = 0;
  int items_taken    = 0;
  int replies_seen   = 0;
  int fail_count     = 0;
  int frames_sent    = 0;
  int starts_refused = 0;
  int writes_refused = 0;
  int cycles         = 0;

  // Traffic shaping shared with the driver and the stall process
  bit no_idle    = 1'b0;
  int hold_token = 0;

  rgb_led_chain_bit_serializer_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Reply prediction. Apply one accepted command to the shadow state and
  // return the reply the block must give for it.
  // ---------------------------------------------------------------------------
  function automatic rlbs_pkg::out_t serialize_cmd(rlbs_pkg::in_t cmd);
    rlbs_pkg::out_t rep;
    int             pre;
    int             total;
    int             pc;
    rep        = '0;
    rep.status = rlbs_pkg::ST_OK;
    case (cmd.func)
      rlbs_pkg::FN_WRITE: begin
        if (cmd.led_number >= rlbs_pkg::NUM_LEDS) begin
          rep.status = rlbs_pkg::ST_RANGE;
          writes_refused++;
        end else begin
          grb_store[cmd.led_number] = {cmd.green, cmd.red, cmd.blue};
        end
      end
      rlbs_pkg::FN_START: begin
        // A running frame is never restarted
        if (frame_on) begin
          rep.status = rlbs_pkg::ST_BUSY;
          starts_refused++;
        end else begin
          frame_on   = 1'b1;
          period_cnt = '0;
          slot_bit   = '0;
        end
      end
      rlbs_pkg::FN_SLOT: begin
        if (!frame_on) begin
          rep.status = rlbs_pkg::ST_IDLE;
        end else begin
          pre   = int'(regs_shadow.reset_pre_periods);
          total = pre + rlbs_pkg::NUM_LEDS + int'(regs_shadow.reset_post_periods) +
                  rlbs_pkg::EXTRA_POST;
          pc    = int'(period_cnt);
          // Only the data periods carry a nonzero duty; bits go out MSB first, GRB order
          if (pc >= pre && pc < pre + rlbs_pkg::NUM_LEDS) begin
            rep.duty = grb_store[pc - pre][rlbs_pkg::COLOR_W - 1 - int'(slot_bit)] ?
                       regs_shadow.duty_one : regs_shadow.duty_zero;
          end
          slot_bit++;
          if (slot_bit >= rlbs_pkg::SLOTS_PER_PERIOD) begin
            slot_bit   = '0;
            period_cnt = period_cnt + rlbs_pkg::PC_W'(1);
            // Registers may have shrunk the frame, so the end test is "reached or passed"
            if (int'(period_cnt) >= total) begin
              frame_on   = 1'b0;
              period_cnt = '0;
              rep.last   = 1'b1;
              frames_sent++;
            end
          end
        end
      end
      default: ;
    endcase
    rep.busy_res = frame_on;
    return rep;
  endfunction

  // Slot requests still needed to finish the running frame
  function automatic int slots_left();
    int total;
    total = int'(regs_shadow.reset_pre_periods) + rlbs_pkg::NUM_LEDS +
            int'(regs_shadow.reset_post_periods) + rlbs_pkg::EXTRA_POST;
    if (!frame_on) return 0;
    if (int'(period_cnt) >= total) return rlbs_pkg::SLOTS_PER_PERIOD - int'(slot_bit);
    return (total - int'(period_cnt)) * rlbs_pkg::SLOTS_PER_PERIOD - int'(slot_bit);
  endfunction

  // Sender gap after an item: mostly none, sometimes short, rarely long
  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 20);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: hold the current item until it is taken, then advance to the next
  // queued one after a random gap. Every accepted item is predicted here.
  // ---------------------------------------------------------------------------
  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_replies.push_back(serialize_cmd(in_item));
        items_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          in_item  <= pending_cmds.pop_front();
          in_valid <= 1'b1;
          gap_left = draw_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each accepted reply with the oldest prediction.
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, logic [rlbs_pkg::DUTY_W-1:0] want,
                             logic [rlbs_pkg::DUTY_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : reply_check
    rlbs_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_replies.size() == 0) begin
        $error("reply with no item outstanding: %p", out_item);
        fail_count++;
      end else begin
        want = expected_replies.pop_front();
        check_field("status", rlbs_pkg::DUTY_W'(want.status),
                    rlbs_pkg::DUTY_W'(out_item.status));
        check_field("duty", want.duty, out_item.duty);
        check_field("last", rlbs_pkg::DUTY_W'(want.last),
                    rlbs_pkg::DUTY_W'(out_item.last));
        check_field("busy_res", rlbs_pkg::DUTY_W'(want.busy_res),
                    rlbs_pkg::DUTY_W'(out_item.busy_res));
        replies_seen++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver stall. Random stalls of mixed length, plus a long hold-off each
  // time the stimulus bumps hold_token, counted here in cycles.
  // ---------------------------------------------------------------------------
  int stall_left = 0;
  int hold_seen  = 0;

  always @(posedge clk) begin : stall_gen
    int r;
    r = $urandom_range(0, 99);
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_token != hold_seen) begin
      hold_seen  = hold_token;
      stall_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (no_idle || r < 70) begin
      out_stall <= 1'b0;
    end else if (r < 96) begin
      stall_left = $urandom_range(0, 2);
      out_stall <= 1'b1;
    end else begin
      stall_left = $urandom_range(10, 30);
      out_stall <= 1'b1;
    end
  end

  // Hang guard
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_cmd(rlbs_pkg::func_e_t f, logic [rlbs_pkg::LED_NUM_W-1:0] led,
                           logic [7:0] g, logic [7:0] r, logic [7:0] b);
    rlbs_pkg::in_t c;
    c.func       = f;
    c.led_number = led;
    c.green      = g;
    c.red        = r;
    c.blue       = b;
    pending_cmds.push_back(c);
    items_queued++;
  endtask

  // Fields that the command ignores still get random values
  task automatic queue_random(rlbs_pkg::func_e_t f);
    queue_cmd(f, rlbs_pkg::LED_NUM_W'($urandom_range(0, 1023)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endtask

  // Anything but a slot request: most often in-range color writes
  task automatic queue_noise();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      queue_cmd(rlbs_pkg::FN_WRITE,
                rlbs_pkg::LED_NUM_W'($urandom_range(0, rlbs_pkg::NUM_LEDS - 1)),
                8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)));
    end else if (r < 60) begin
      queue_random(rlbs_pkg::FN_WRITE);
    end else if (r < 75) begin
      queue_random(rlbs_pkg::FN_START);
    end else begin
      queue_random(rlbs_pkg::FN_NONE);
    end
  endtask

  // A run of slot requests with other commands mixed in
  task automatic queue_slots(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 12) queue_noise();
      queue_random(rlbs_pkg::FN_SLOT);
    end
  endtask

  // Pause the sender until every reply is in, then let the pipeline settle
  task automatic wait_idle();
    do @(posedge clk); while (replies_seen != items_queued);
    repeat (4) @(posedge clk);
  endtask

  // Back-to-back register write; valid stays high between writes
  task automatic write_reg(rlbs_pkg::cfg_reg_e_t idx, logic [rlbs_pkg::DUTY_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      rlbs_pkg::CFG_PRE:  regs_shadow.reset_pre_periods  = val[rlbs_pkg::PERIOD_W-1:0];
      rlbs_pkg::CFG_POST: regs_shadow.reset_post_periods = val[rlbs_pkg::PERIOD_W-1:0];
      rlbs_pkg::CFG_ONE:  regs_shadow.duty_one           = val;
      rlbs_pkg::CFG_ZERO: regs_shadow.duty_zero          = val;
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [rlbs_pkg::PERIOD_W-1:0] pre,
                          logic [rlbs_pkg::PERIOD_W-1:0] post,
                          logic [rlbs_pkg::DUTY_W-1:0] one,
                          logic [rlbs_pkg::DUTY_W-1:0] zero);
    write_reg(rlbs_pkg::CFG_PRE, rlbs_pkg::DUTY_W'(pre));
    write_reg(rlbs_pkg::CFG_POST, rlbs_pkg::DUTY_W'(post));
    write_reg(rlbs_pkg::CFG_ONE, one);
    write_reg(rlbs_pkg::CFG_ZERO, zero);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    // Shadow state starts at the block's reset values
    foreach (grb_store[i]) grb_store[i] = '0;
    frame_on                       = 1'b0;
    period_cnt                     = '0;
    slot_bit                       = '0;
    regs_shadow.reset_pre_periods  = 10'd50;
    regs_shadow.reset_post_periods = 10'd50;
    regs_shadow.duty_one           = 16'd60;
    regs_shadow.duty_zero          = 16'd30;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part under the reset register values
    queue_cmd(rlbs_pkg::FN_SLOT, 10'h3FF, 8'hFF, 8'hFF, 8'hFF);  // slot with no frame running
    queue_cmd(rlbs_pkg::FN_NONE, 10'h3FF, 8'hFF, 8'hFF, 8'hFF);  // unused command, all ones
    queue_cmd(rlbs_pkg::FN_NONE, 10'h000, 8'h00, 8'h00, 8'h00);
    queue_cmd(rlbs_pkg::FN_WRITE, 10'd0, 8'hFF, 8'h00, 8'hFF);
    // last LED, then the first index out of range
    queue_cmd(rlbs_pkg::FN_WRITE, rlbs_pkg::LED_NUM_W'(rlbs_pkg::NUM_LEDS - 1),
              8'h00, 8'hFF, 8'h00);
    queue_cmd(rlbs_pkg::FN_WRITE, rlbs_pkg::LED_NUM_W'(rlbs_pkg::NUM_LEDS),
              8'hAA, 8'h55, 8'hAA);
    queue_cmd(rlbs_pkg::FN_WRITE, 10'h3FF, 8'hFF, 8'hFF, 8'hFF); // highest index, refused
    queue_cmd(rlbs_pkg::FN_WRITE, 10'd1, 8'h80, 8'h01, 8'h7E);
    queue_cmd(rlbs_pkg::FN_START, 10'd0, 8'h00, 8'h00, 8'h00);
    queue_cmd(rlbs_pkg::FN_START, 10'd0, 8'h00, 8'h00, 8'h00);   // refused, frame running
    repeat (3) queue_cmd(rlbs_pkg::FN_SLOT, 10'd0, 8'h00, 8'h00, 8'h00);
    queue_cmd(rlbs_pkg::FN_NONE, 10'd5, 8'h12, 8'h34, 8'h56);    // ignored mid-frame
    wait_idle();

    // Drop the reset periods while the frame runs: data starts at once
    set_regs(10'd0, 10'd0, 16'hFFFF, 16'h0000);
    repeat (4) queue_cmd(rlbs_pkg::FN_SLOT, 10'd0, 8'h00, 8'h00, 8'h00);
    queue_cmd(rlbs_pkg::FN_WRITE, 10'd0, 8'h5A, 8'hC3, 8'h3C);   // recolor the LED being sent
    repeat (4) queue_cmd(rlbs_pkg::FN_SLOT, 10'd0, 8'h00, 8'h00, 8'h00);
    wait_idle();

    // Random part 1: longest reset periods in the same frame, then shrink them
    // and run the frame to its final slot
    set_regs(10'd1023, 10'd1023, rlbs_pkg::DUTY_W'($urandom_range(0, 65535)),
             rlbs_pkg::DUTY_W'($urandom_range(0, 65535)));
    queue_random(rlbs_pkg::FN_START);
    queue_slots(48);
    wait_idle();
    set_regs(10'd2, 10'd0, 16'h0000, 16'hFFFF);
    queue_slots(slots_left());
    repeat (3) queue_random(rlbs_pkg::FN_SLOT);
    wait_idle();

    // Random part 2: no gaps or random stalls, one long hold-off at the output
    // while the sender keeps offering items, so the block backs up
    set_regs(rlbs_pkg::PERIOD_W'($urandom_range(0, 15)),
             rlbs_pkg::PERIOD_W'($urandom_range(0, 15)),
             rlbs_pkg::DUTY_W'($urandom_range(0, 65535)),
             rlbs_pkg::DUTY_W'($urandom_range(0, 65535)));
    no_idle = 1'b1;
    queue_random(rlbs_pkg::FN_START);
    queue_slots(100);
    hold_token++;
    wait_idle();
    no_idle = 1'b0;

    // Let the last replies settle before the final check
    repeat (10) @(posedge clk);
    if (expected_replies.size() != 0) begin
      $error("%0d replies never arrived", expected_replies.size());
      fail_count++;
    end

    $display("Run covered %0d items and %0d replies over %0d cycles.",
             items_taken, replies_seen, cycles);
    $display("Frames completed %0d, starts refused %0d, color writes refused %0d.",
             frames_sent, starts_refused, writes_refused);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
